/* sv/allan_deviation_estimator_top_assert.svh */
// Assertion macros shared by the estimator modules.
`ifndef ALLAN_DEVIATION_ESTIMATOR_TOP_ASSERT_SVH
`define ALLAN_DEVIATION_ESTIMATOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define ADE_ASSERT(name, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ade check failed");
`define ADE_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ade check failed");
`else
`define ADE_ASSERT(name, prop)
`define ADE_ASSERT_NEXT(name, ante, cons)
`endif

`endif

/* sv/ade_pkg.sv */
package ade_pkg;

    localparam int MAX_FACTOR  = 1024;
    localparam int MAX_SAMPLES = 1048576;
    localparam int PH_DEPTH    = 2 * MAX_FACTOR;
    localparam int PH_AW       = $clog2(PH_DEPTH);
    localparam int DF_AW       = $clog2(MAX_FACTOR);
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

    localparam logic [19:0] MUL_1E6     = 20'd1000000;
    localparam int          MUL_STEPS   = 32;
    localparam int          DIV_STEPS   = 256;
    localparam int          SQRT_STEPS  = 128;

    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_FACTOR = 2'd1;
    localparam logic [1:0] REG_TAU    = 2'd2;
    localparam logic [1:0] REG_LIMIT  = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_CONFIG = 2'd1;
    localparam logic [1:0] ST_FEW    = 2'd2;
    localparam logic [1:0] ST_RANGE  = 2'd3;

    typedef struct packed {
        logic signed [47:0] phase_ps;
        logic               last_sample;
    } ade_in_t;

    typedef struct packed {
        logic [63:0] deviation_fs;
        logic [1:0]  status;
        logic [20:0] term_count;
    } ade_out_t;

    typedef struct packed {
        logic        mode;
        logic [10:0] factor;
        logic [31:0] tau;
        logic [46:0] limit;
    } ade_cfg_t;

    typedef struct packed {
        logic [47:0]      x;
        logic             last;
        logic             active;
        logic             do_diff;
        logic             win_sub;
        logic             win_sq;
        logic [PH_AW-1:0] addr_m;
        logic [PH_AW-1:0] addr_2m;
        logic [PH_AW-1:0] addr_wr;
        logic [DF_AW-1:0] dslot;
        logic [DF_AW-1:0] dold;
        logic [20:0]      n;
        logic             range_err;
    } ade_entry_t;

endpackage

/* sv/allan_deviation_estimator_top.sv */
// channel | valid    | stall     | payload
// input   | in_valid | in_stall  | in_data  (ade_in_t)
// output  | out_valid| out_stall | out_data (ade_out_t)
// config  | cfg_wr_en| -         | cfg_index, cfg_data
// Per sample, the back-end sequencer computes the second difference; where one is due, it
// squares it (Allan) or adds it to the window sum and squares that sum once the window
// fills (modified), on its shared 32x32 squaring multiplier.
// A record end runs a check step, 32 limb steps of x1e6, the m^p scaling, two
// 256-step restoring divisions and a 128-step square root.
// Reset clears control and sums only; history memories are not cleared.
// A 4-entry queue lets the front keep taking samples while the back is busy;
// a result held by out_stall blocks the back at the next record check.
module allan_deviation_estimator_top
    import ade_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  ade_in_t     in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output ade_out_t    out_data,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [46:0] cfg_data
);

    ade_cfg_t   cfg;
    logic       rec_clear;
    logic       push_valid;
    logic       push_stall;
    ade_entry_t push_data;
    logic       pop_valid;
    logic       pop_stall;
    ade_entry_t pop_data;

    ade_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cfg        (cfg),
        .rec_clear  (rec_clear),
        .push_valid (push_valid),
        .push_stall (push_stall),
        .push_data  (push_data)
    );

    ade_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_stall (push_stall),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_stall  (pop_stall),
        .pop_data   (pop_data)
    );

    ade_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .rec_clear (rec_clear),
        .pop_valid (pop_valid),
        .pop_stall (pop_stall),
        .pop_data  (pop_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

/* sv/ade_fifo.sv */
`include "allan_deviation_estimator_top_assert.svh"
module ade_fifo
    import ade_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push_valid,
    output logic       push_stall,
    input  ade_entry_t push_data,
    output logic       pop_valid,
    input  logic       pop_stall,
    output ade_entry_t pop_data
);

    ade_entry_t         mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg;
    logic               push;
    logic               pop;

    assign push_stall = (count_reg == (FIFO_AW + 1)'(FIFO_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && !push_stall;
    assign pop        = pop_valid && !pop_stall;
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    `ADE_ASSERT_NEXT(a_fifo_fill, push && !pop, count_reg == $past(count_reg) + 1'b1)
    `ADE_ASSERT_NEXT(a_fifo_drain, pop && !push, count_reg == $past(count_reg) - 1'b1)

endmodule

/* sv/ade_front.sv */
`include "allan_deviation_estimator_top_assert.svh"
module ade_front
    import ade_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  ade_in_t     in_data,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [46:0] cfg_data,
    output ade_cfg_t    cfg,
    output logic        rec_clear,
    output logic        push_valid,
    input  logic        push_stall,
    output ade_entry_t  push_data
);

    ade_cfg_t    cfg_reg;
    logic [20:0] count_reg;
    logic        range_reg;

    logic [47:0] x;
    logic [47:0] mag;
    logic        over;
    logic        active;
    logic        m_ok;
    logic [19:0] k;
    logic [19:0] m20;
    logic [19:0] two_m;
    logic [19:0] km;
    logic [19:0] t;
    logic [19:0] tm;
    logic [20:0] n;
    logic        range_now;
    logic        accept;

    assign cfg       = cfg_reg;
    assign rec_clear = cfg_wr_en;
    assign in_stall  = push_stall;
    assign push_valid = in_valid;
    assign accept    = in_valid && !push_stall;

    assign x      = in_data.phase_ps;
    assign mag    = x[47] ? (48'd0 - x) : x;
    assign over   = mag > {1'b0, cfg_reg.limit};
    assign active = count_reg < 21'(MAX_SAMPLES);
    assign m_ok   = (cfg_reg.factor != '0) && (cfg_reg.factor <= 11'(MAX_FACTOR));
    assign k      = count_reg[19:0];
    assign m20    = 20'(cfg_reg.factor);
    assign two_m  = 20'({cfg_reg.factor, 1'b0});
    assign km     = k - m20;
    assign t      = k - two_m;
    assign tm     = t - m20;
    assign n      = active ? count_reg + 1'b1 : count_reg;
    assign range_now = range_reg || (active && over);

    always_comb
    begin
        push_data           = '0;
        push_data.x         = x;
        push_data.last      = in_data.last_sample;
        push_data.active    = active;
        push_data.do_diff   = active && m_ok && (21'(k) >= 21'(two_m));
        push_data.win_sub   = t >= m20;
        push_data.win_sq    = (21'(t) + 21'd1) >= 21'(m20);
        push_data.addr_m    = km[PH_AW-1:0];
        push_data.addr_2m   = t[PH_AW-1:0];
        push_data.addr_wr   = k[PH_AW-1:0];
        push_data.dslot     = t[DF_AW-1:0];
        push_data.dold      = tm[DF_AW-1:0];
        push_data.n         = n;
        push_data.range_err = range_now;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode   <= 1'b0;
            cfg_reg.factor <= 11'd1;
            cfg_reg.tau    <= 32'd1000000000;
            cfg_reg.limit  <= 47'd2000000000000;
            count_reg      <= '0;
            range_reg      <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_MODE:   cfg_reg.mode   <= cfg_data[0];
                REG_FACTOR: cfg_reg.factor <= cfg_data[10:0];
                REG_TAU:    cfg_reg.tau    <= cfg_data[31:0];
                REG_LIMIT:  cfg_reg.limit  <= cfg_data;
                default:    cfg_reg        <= cfg_reg;
            endcase
            count_reg <= '0;
            range_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (in_data.last_sample)
            begin
                count_reg <= '0;
                range_reg <= 1'b0;
            end
            else
            begin
                count_reg <= n;
                range_reg <= range_now;
            end
        end
    end

    `ADE_ASSERT(a_count_max, count_reg <= 21'(MAX_SAMPLES))

endmodule

/* sv/ade_back.sv */
`include "allan_deviation_estimator_top_assert.svh"
module ade_back
    import ade_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  ade_cfg_t   cfg,
    input  logic       rec_clear,
    input  logic       pop_valid,
    output logic       pop_stall,
    input  ade_entry_t pop_data,
    output logic       out_valid,
    input  logic       out_stall,
    output ade_out_t   out_data
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DIFF  = 4'd1;
    localparam logic [3:0] S_WIN   = 4'd2;
    localparam logic [3:0] S_WMAG  = 4'd3;
    localparam logic [3:0] S_SQ0   = 4'd4;
    localparam logic [3:0] S_SQ1   = 4'd5;
    localparam logic [3:0] S_SQ2   = 4'd6;
    localparam logic [3:0] S_SQ3   = 4'd7;
    localparam logic [3:0] S_CHECK = 4'd8;
    localparam logic [3:0] S_NUM   = 4'd9;
    localparam logic [3:0] S_DEN   = 4'd10;
    localparam logic [3:0] S_DIV   = 4'd11;
    localparam logic [3:0] S_SQRT  = 4'd12;
    localparam logic [3:0] S_EMIT  = 4'd13;

    logic [47:0] phase_mem [PH_DEPTH];
    logic [50:0] diff_mem  [MAX_FACTOR];

    logic [3:0]   state_reg,     state_next;
    ade_entry_t   item_reg,      item_next;
    logic [50:0]  d_reg,         d_next;
    logic [60:0]  wsum_reg,      wsum_next;
    logic [60:0]  mag_reg,       mag_next;
    logic [63:0]  prod_reg,      prod_next;
    logic [191:0] acc_reg,       acc_next;
    logic [255:0] num_reg,       num_next;
    logic [63:0]  den_reg,       den_next;
    logic [63:0]  rem_reg,       rem_next;
    logic [129:0] srem_reg,      srem_next;
    logic [127:0] root_reg,      root_next;
    logic [20:0]  carry_reg,     carry_next;
    logic [8:0]   cnt_reg,       cnt_next;
    logic         pass_reg,      pass_next;
    logic         out_valid_reg, out_valid_next;
    ade_out_t     out_data_reg,  out_data_next;
    logic [47:0]  xm_reg;
    logic [47:0]  x2m_reg;
    logic [50:0]  dold_reg;

    logic         pop;
    logic [50:0]  d_calc;
    logic [50:0]  d_neg;
    logic [60:0]  wsum_calc;
    logic [60:0]  wsum_neg;
    logic [31:0]  mul_a;
    logic [31:0]  mul_b;
    logic [63:0]  mul_p;
    logic [52:0]  num_p;
    logic [63:0]  den_p;
    logic [64:0]  div_r2;
    logic         div_ge;
    logic [64:0]  div_diff;
    logic [129:0] sq_r2;
    logic [129:0] sq_trial;
    logic         sq_ge;
    logic [127:0] root_step;
    logic         m_ok;
    logic [11:0]  two_m;
    logic [12:0]  three_m;
    logic         few;
    logic [20:0]  terms_calc;
    logic [8:0]   den_last;

    assign pop_stall = (state_reg != S_IDLE);
    assign pop       = pop_valid && !pop_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign d_calc = {{3{item_reg.x[47]}}, item_reg.x}
                  - {{2{xm_reg[47]}}, xm_reg, 1'b0}
                  + {{3{x2m_reg[47]}}, x2m_reg};
    assign d_neg  = 51'd0 - d_calc;
    assign wsum_calc = wsum_reg + {{10{d_reg[50]}}, d_reg}
                     - (item_reg.win_sub ? {{10{dold_reg[50]}}, dold_reg} : 61'd0);
    assign wsum_neg  = 61'd0 - wsum_reg;

    // square of mag as three 32-bit partial products
    assign mul_a = (state_reg == S_SQ2) ? {3'd0, mag_reg[60:32]} : mag_reg[31:0];
    assign mul_b = (state_reg == S_SQ0) ? mag_reg[31:0] : {3'd0, mag_reg[60:32]};
    assign mul_p = 64'(mul_a) * 64'(mul_b);

    assign num_p = 53'(num_reg[31:0]) * 53'(MUL_1E6) + 53'(carry_reg);
    assign den_p = den_reg * 64'(cfg.factor);

    assign div_r2   = {rem_reg, num_reg[255]};
    assign div_ge   = div_r2 >= {1'b0, den_reg};
    assign div_diff = div_r2 - {1'b0, den_reg};

    assign sq_r2     = {srem_reg[127:0], num_reg[255:254]};
    assign sq_trial  = {root_reg, 2'b01};
    assign sq_ge     = sq_r2 >= sq_trial;
    assign root_step = {root_reg[126:0], sq_ge};

    assign m_ok    = (cfg.factor != '0) && (cfg.factor <= 11'(MAX_FACTOR));
    assign two_m   = {cfg.factor, 1'b0};
    assign three_m = 13'(two_m) + 13'(cfg.factor);
    assign few     = cfg.mode ? (22'(item_reg.n) < 22'(three_m))
                              : (22'(item_reg.n) < 22'(two_m) + 22'd1);
    assign terms_calc = cfg.mode ? item_reg.n - 21'(three_m) + 21'd1
                                 : item_reg.n - 21'(two_m);
    assign den_last = cfg.mode ? 9'd3 : 9'd1;

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        d_next         = d_reg;
        wsum_next      = wsum_reg;
        mag_next       = mag_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        srem_next      = srem_reg;
        root_next      = root_reg;
        carry_next     = carry_reg;
        cnt_next       = cnt_reg;
        pass_next      = pass_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (pop)
                begin
                    item_next  = pop_data;
                    state_next = S_DIFF;
                end
            end
            S_DIFF:
            begin
                d_next = d_calc;
                if (!item_reg.do_diff)
                    state_next = item_reg.last ? S_CHECK : S_IDLE;
                else if (cfg.mode)
                    state_next = S_WIN;
                else
                begin
                    mag_next   = {10'd0, d_calc[50] ? d_neg : d_calc};
                    state_next = S_SQ0;
                end
            end
            S_WIN:
            begin
                wsum_next = wsum_calc;
                if (item_reg.win_sq)
                    state_next = S_WMAG;
                else
                    state_next = item_reg.last ? S_CHECK : S_IDLE;
            end
            S_WMAG:
            begin
                mag_next   = wsum_reg[60] ? wsum_neg : wsum_reg;
                state_next = S_SQ0;
            end
            S_SQ0:
            begin
                prod_next  = mul_p;
                state_next = S_SQ1;
            end
            S_SQ1:
            begin
                acc_next   = acc_reg + {128'd0, prod_reg};
                prod_next  = mul_p;
                state_next = S_SQ2;
            end
            S_SQ2:
            begin
                acc_next   = acc_reg + {95'd0, prod_reg, 33'd0};
                prod_next  = mul_p;
                state_next = S_SQ3;
            end
            S_SQ3:
            begin
                acc_next   = acc_reg + {64'd0, prod_reg, 64'd0};
                state_next = item_reg.last ? S_CHECK : S_IDLE;
            end
            S_CHECK:
            begin
                // the result register is reused, so a waiting result must leave first
                if (!out_valid_reg)
                begin
                    out_data_next.deviation_fs = '0;
                    out_data_next.term_count   = '0;
                    if (!m_ok || cfg.tau == '0)
                    begin
                        out_data_next.status = ST_CONFIG;
                        state_next           = S_EMIT;
                    end
                    else if (few)
                    begin
                        out_data_next.status = ST_FEW;
                        state_next           = S_EMIT;
                    end
                    else if (item_reg.range_err)
                    begin
                        out_data_next.status = ST_RANGE;
                        state_next           = S_EMIT;
                    end
                    else
                    begin
                        out_data_next.status     = ST_OK;
                        out_data_next.term_count = terms_calc;
                        num_next   = {64'd0, acc_reg};
                        den_next   = {42'd0, terms_calc, 1'b0};
                        carry_next = '0;
                        cnt_next   = '0;
                        state_next = S_NUM;
                    end
                end
            end
            S_NUM:
            begin
                // four passes of x1e6 over eight 32-bit limbs, low limb first
                num_next   = {num_p[31:0], num_reg[255:32]};
                carry_next = (cnt_reg[2:0] == 3'd7) ? 21'd0 : num_p[52:32];
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == 9'(MUL_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_DEN;
                end
            end
            S_DEN:
            begin
                den_next = den_p;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == den_last)
                begin
                    rem_next   = '0;
                    cnt_next   = '0;
                    pass_next  = 1'b0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                rem_next = div_ge ? div_diff[63:0] : div_r2[63:0];
                num_next = {num_reg[254:0], div_ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 9'(DIV_STEPS - 1))
                begin
                    cnt_next = '0;
                    if (!pass_reg)
                    begin
                        srem_next  = '0;
                        root_next  = '0;
                        state_next = S_SQRT;
                    end
                    else
                    begin
                        out_data_next.deviation_fs = (|num_next[255:64]) ? '1
                                                                         : num_next[63:0];
                        state_next = S_EMIT;
                    end
                end
            end
            S_SQRT:
            begin
                srem_next = sq_ge ? sq_r2 - sq_trial : sq_r2;
                root_next = root_step;
                num_next  = {num_reg[253:0], 2'b00};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == 9'(SQRT_STEPS - 1))
                begin
                    num_next   = {128'd0, root_step};
                    den_next   = {32'd0, cfg.tau};
                    rem_next   = '0;
                    pass_next  = 1'b1;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    acc_next       = '0;
                    wsum_next      = '0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (rec_clear)
        begin
            acc_next  = '0;
            wsum_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
            wsum_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            acc_reg       <= acc_next;
            wsum_reg      <= wsum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        d_reg        <= d_next;
        mag_reg      <= mag_next;
        prod_reg     <= prod_next;
        num_reg      <= num_next;
        den_reg      <= den_next;
        rem_reg      <= rem_next;
        srem_reg     <= srem_next;
        root_reg     <= root_next;
        carry_reg    <= carry_next;
        cnt_reg      <= cnt_next;
        pass_reg     <= pass_next;
        out_data_reg <= out_data_next;
    end

    // history reads at pop, writes later in the same transaction
    always_ff @(posedge clk)
    begin
        if (state_reg == S_DIFF && item_reg.active)
            phase_mem[item_reg.addr_wr] <= item_reg.x;
        if (pop)
        begin
            xm_reg  <= phase_mem[pop_data.addr_m];
            x2m_reg <= phase_mem[pop_data.addr_2m];
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_WIN)
            diff_mem[item_reg.dslot] <= d_reg;
        if (pop)
            dold_reg <= diff_mem[pop_data.dold];
    end

    `ADE_ASSERT(a_err_zero, (out_valid_reg && out_data_reg.status != ST_OK) |-> (out_data_reg.deviation_fs == '0 && out_data_reg.term_count == '0))
    `ADE_ASSERT(a_emit_src, $rose(out_valid_reg) |-> $past(state_reg == S_EMIT))

endmodule
